[hdl/wsm_pkg.sv]
// shared constants and types for the wildcard signature matcher
package wsm_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int POSITION_BITS = 32;

    localparam int IDX_BITS = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam int LEN_BITS = $clog2(PATTERN_BYTES + 1);
    localparam int OFS_BITS = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_PATTERN_LOW  = 3'd0;
    localparam cfg_index_t CFG_PATTERN_HIGH = 3'd1;
    localparam cfg_index_t CFG_CARE_MASK    = 3'd2;
    localparam cfg_index_t CFG_PATTERN_LEN  = 3'd3;
    localparam cfg_index_t CFG_EP_ONLY      = 3'd4;
    localparam cfg_index_t CFG_ENTRY_OFFSET = 3'd5;

    typedef logic [7:0]               byte_t;
    typedef logic [LEN_BITS-1:0]      len_t;
    typedef logic [POSITION_BITS-1:0] pos_t;

endpackage

[hdl/wildcard_signature_matcher_unit.sv]
// wildcard nibble signature matcher: streams file bytes and reports the best prefix match
// latency: the result of a last beat is valid in the cycle after that beat is accepted
// throughput: one file byte per unstalled cycle, set by the single parallel window compare stage
// backpressure: input is taken whenever the result register is empty or being drained
// reset: config registers return to defaults (length 1), scan state and window clear
// after each reported result the scan state clears for the next file, config is kept
module wildcard_signature_matcher_unit
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  wsm_pkg::cfg_index_t                cfg_index,
    input  logic [wsm_pkg::CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // file_byte
    input  logic                               s_axis_tlast,   // last

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata    // best_match_bytes, full_match, no_fit, pad
);

    localparam int PB = wsm_pkg::PATTERN_BYTES;

    logic [63:0]                        pattern_low_reg;
    logic [63:0]                        pattern_high_reg;
    logic [31:0]                        care_mask_reg;
    logic [4:0]                         pattern_len_reg;
    logic                               ep_only_reg;
    logic [31:0]                        entry_offset_reg;

    wsm_pkg::byte_t                     window_reg [PB];
    wsm_pkg::byte_t                     window_next [PB];
    wsm_pkg::pos_t                      position_reg;
    wsm_pkg::pos_t                      position_next;
    wsm_pkg::len_t                      best_reg;
    wsm_pkg::len_t                      best_next;

    logic                               out_valid_reg;
    logic [7:0]                         out_data_reg;
    logic [7:0]                         out_data_next;

    logic                               accept;
    wsm_pkg::len_t                      len_eff;
    wsm_pkg::byte_t                     sig_byte [PB];
    logic [2*PB-1:0]                    care_bits;
    logic [PB-1:0]                      byte_ok;
    wsm_pkg::len_t                      prefix;
    logic                               found;
    logic                               fits;
    logic                               tested;
    wsm_pkg::pos_t                      start;
    logic [wsm_pkg::IDX_BITS:0]         widx;
    wsm_pkg::byte_t                     wbyte;
    wsm_pkg::byte_t                     diff;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= '0;
            pattern_len_reg  <= 5'd1;
            ep_only_reg      <= 1'b0;
            entry_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wsm_pkg::CFG_PATTERN_LOW:  pattern_low_reg  <= cfg_data[63:0];
                wsm_pkg::CFG_PATTERN_HIGH: pattern_high_reg <= cfg_data[63:0];
                wsm_pkg::CFG_CARE_MASK:    care_mask_reg    <= cfg_data[31:0];
                wsm_pkg::CFG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[4:0];
                wsm_pkg::CFG_EP_ONLY:      ep_only_reg      <= cfg_data[0];
                wsm_pkg::CFG_ENTRY_OFFSET: entry_offset_reg <= cfg_data[31:0];
                default:                   ;
            endcase
        end
    end

    // clamped length, signature bytes and care bits
    always_comb
    begin
        if (pattern_len_reg == 5'd0)
        begin
            len_eff = wsm_pkg::len_t'(1);
        end
        else if (int'(pattern_len_reg) > PB)
        begin
            len_eff = wsm_pkg::len_t'(PB);
        end
        else
        begin
            len_eff = wsm_pkg::len_t'(pattern_len_reg);
        end

        for (int k = 0; k < PB; k++)
        begin
            if (k < 8)
            begin
                sig_byte[k] = pattern_low_reg[8*k +: 8];
            end
            else if (k < 16)
            begin
                sig_byte[k] = pattern_high_reg[8*(k-8) +: 8];
            end
            else
            begin
                sig_byte[k] = 8'h00;
            end
        end

        for (int b = 0; b < 2*PB; b++)
        begin
            care_bits[b] = (b < 32) ? care_mask_reg[b] : 1'b0;
        end
    end

    // shifted window and saturating byte count
    always_comb
    begin
        for (int i = 0; i < PB - 1; i++)
        begin
            window_next[i] = window_reg[i+1];
        end
        window_next[PB-1] = s_axis_tdata;

        if (position_reg == '1)
        begin
            position_next = position_reg;
        end
        else
        begin
            position_next = position_reg + wsm_pkg::pos_t'(1);
        end
    end

    // per-byte nibble compare against the newest len_eff bytes
    always_comb
    begin
        widx  = '0;
        wbyte = '0;
        diff  = '0;
        for (int k = 0; k < PB; k++)
        begin
            widx = (wsm_pkg::IDX_BITS+1)'(PB) - (wsm_pkg::IDX_BITS+1)'(len_eff)
                 + (wsm_pkg::IDX_BITS+1)'(k);
            if (int'(widx) < PB)
            begin
                wbyte = window_next[widx[wsm_pkg::IDX_BITS-1:0]];
            end
            else
            begin
                wbyte = 8'h00;
            end
            diff = wbyte ^ sig_byte[k];
            byte_ok[k] = !(care_bits[2*k] && (diff[7:4] != 4'h0))
                      && !(care_bits[2*k+1] && (diff[3:0] != 4'h0));
        end
    end

    // matched prefix length
    always_comb
    begin
        prefix = len_eff;
        found  = 1'b0;
        for (int k = 0; k < PB; k++)
        begin
            if (!found && (wsm_pkg::len_t'(k) < len_eff) && !byte_ok[k])
            begin
                prefix = wsm_pkg::len_t'(k);
                found  = 1'b1;
            end
        end
    end

    // window test, best update and result word
    always_comb
    begin
        fits   = position_next >= wsm_pkg::pos_t'(len_eff);
        start  = position_next - wsm_pkg::pos_t'(len_eff);
        tested = fits && (!ep_only_reg
               || (wsm_pkg::OFS_BITS'(start) == wsm_pkg::OFS_BITS'(entry_offset_reg)));

        if (tested && (prefix > best_reg))
        begin
            best_next = prefix;
        end
        else
        begin
            best_next = best_reg;
        end

        if (position_next <= wsm_pkg::pos_t'(len_eff))
        begin
            out_data_next = {1'b0, 1'b1, 1'b0, 5'd0};
        end
        else
        begin
            out_data_next = {1'b0, 1'b0, (best_next == len_eff), 5'(best_next)};
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PB; i++)
            begin
                window_reg[i] <= '0;
            end
            position_reg <= '0;
            best_reg     <= '0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                for (int i = 0; i < PB; i++)
                begin
                    window_reg[i] <= '0;
                end
                position_reg <= '0;
                best_reg     <= '0;
            end
            else
            begin
                for (int i = 0; i < PB; i++)
                begin
                    window_reg[i] <= window_next[i];
                end
                position_reg <= position_next;
                best_reg     <= best_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && s_axis_tlast)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tlast)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[tb/wildcard_signature_matcher_unit_tb.sv]
// self-checking stream testbench for the wildcard signature matcher unit
module wildcard_signature_matcher_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 12;
    localparam int RANDOM_BEATS  = 1600;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        wsm_pkg::len_t best;
        logic          full;
        logic          nofit;
    } verdict_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    wsm_pkg::cfg_index_t               cfg_index;
    logic [wsm_pkg::CFG_DATA_BITS-1:0] cfg_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [7:0]                        s_axis_tdata;   // file_byte
    logic                              s_axis_tlast;   // last
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [7:0]                        m_axis_tdata;   // best_match_bytes, full_match, no_fit, pad

    // mirror of the block's registers and scan state
    logic [63:0]    sig_lo;
    logic [63:0]    sig_hi;
    logic [31:0]    care_r;
    wsm_pkg::len_t  len_r;
    logic           ep_r;
    logic [31:0]    entry_r;
    wsm_pkg::byte_t win_q [wsm_pkg::PATTERN_BYTES];
    wsm_pkg::pos_t  seen_cnt;
    int             best_q;

    verdict_t pending_verdicts[$];
    int       mismatch_count = 0;
    int       beats_sent;
    int       cycle_count;
    int       tx_gap_pct;
    int       rx_stall_pct;
    int       rx_holds_req;
    int       rx_holds_done;

    wildcard_signature_matcher_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int match_len();
        if (len_r == 0)
            return 1;
        if (len_r > wsm_pkg::PATTERN_BYTES)
            return wsm_pkg::PATTERN_BYTES;
        return int'(len_r);
    endfunction

    function automatic wsm_pkg::byte_t sig_byte(int k);
        if (k < 8)
            return sig_lo[8*k +: 8];
        return sig_hi[8*(k-8) +: 8];
    endfunction

    function automatic int matched_prefix(int n);
        wsm_pkg::byte_t d;
        for (int k = 0; k < n; k++)
        begin
            d = win_q[wsm_pkg::PATTERN_BYTES - n + k] ^ sig_byte(k);
            if (care_r[2*k] && d[7:4] != 4'h0)
                return k;
            if (care_r[2*k+1] && d[3:0] != 4'h0)
                return k;
        end
        return n;
    endfunction

    // signature byte k with random nibbles where the mask allows
    function automatic wsm_pkg::byte_t planted_byte(int k);
        wsm_pkg::byte_t r;
        wsm_pkg::byte_t s;
        r = wsm_pkg::byte_t'($urandom);
        s = sig_byte(k);
        if (care_r[2*k])
            r[7:4] = s[7:4];
        if (care_r[2*k+1])
            r[3:0] = s[3:0];
        return r;
    endfunction

    task automatic clear_scan();
        foreach (win_q[i])
            win_q[i] = 8'h00;
        seen_cnt = '0;
        best_q   = 0;
    endtask

    task automatic track_beat(input wsm_pkg::byte_t b, input bit lst);
        int       n;
        int       m;
        verdict_t v;
        for (int i = 0; i < wsm_pkg::PATTERN_BYTES - 1; i++)
            win_q[i] = win_q[i+1];
        win_q[wsm_pkg::PATTERN_BYTES-1] = b;
        if (seen_cnt != '1)
            seen_cnt++;
        n = match_len();
        if (seen_cnt >= wsm_pkg::pos_t'(n))
        begin
            if (!ep_r || (seen_cnt - wsm_pkg::pos_t'(n)) == wsm_pkg::pos_t'(entry_r))
            begin
                m = matched_prefix(n);
                if (m > best_q)
                    best_q = m;
            end
        end
        if (lst)
        begin
            if (seen_cnt <= wsm_pkg::pos_t'(n))
            begin
                v.best  = '0;
                v.full  = 1'b0;
                v.nofit = 1'b1;
            end
            else
            begin
                v.best  = wsm_pkg::len_t'(best_q);
                v.full  = (best_q == n);
                v.nofit = 1'b0;
            end
            pending_verdicts.push_back(v);
            clear_scan();
        end
    endtask

    task automatic send_beat(input wsm_pkg::byte_t b, input bit lst);
        int gap;
        gap = 0;
        if ($urandom_range(99) < tx_gap_pct)
            gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        track_beat(b, lst);
        beats_sent++;
    endtask

    task automatic send_file(input wsm_pkg::byte_t bytes[$]);
        foreach (bytes[i])
            send_beat(bytes[i], i == bytes.size() - 1);
    endtask

    // drop valid and let every pending result drain
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input wsm_pkg::cfg_index_t idx,
                             input logic [wsm_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            wsm_pkg::CFG_PATTERN_LOW:  sig_lo  = value;
            wsm_pkg::CFG_PATTERN_HIGH: sig_hi  = value;
            wsm_pkg::CFG_CARE_MASK:    care_r  = value[31:0];
            wsm_pkg::CFG_PATTERN_LEN:  len_r   = value[4:0];
            wsm_pkg::CFG_EP_ONLY:      ep_r    = value[0];
            wsm_pkg::CFG_ENTRY_OFFSET: entry_r = value[31:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [31:0] care, input logic [4:0] len,
                                input logic ep, input logic [31:0] entry);
        wait_idle();
        write_reg(wsm_pkg::CFG_PATTERN_LOW, lo);
        write_reg(wsm_pkg::CFG_PATTERN_HIGH, hi);
        write_reg(wsm_pkg::CFG_CARE_MASK, 64'(care));
        write_reg(wsm_pkg::CFG_PATTERN_LEN, 64'(len));
        write_reg(wsm_pkg::CFG_EP_ONLY, 64'(ep));
        write_reg(wsm_pkg::CFG_ENTRY_OFFSET, 64'(entry));
    endtask

    task automatic pick_random_config();
        logic [31:0] care;
        logic [4:0]  len;
        logic [31:0] entry;
        case ($urandom_range(3))
            0:       care = '1;
            1:       care = $urandom;
            default: care = $urandom | $urandom;
        endcase
        case ($urandom_range(9))
            0:       len = 5'd16;
            1:       len = 5'd1;
            2:       len = 5'($urandom_range(0, 31));
            default: len = 5'($urandom_range(1, 16));
        endcase
        case ($urandom_range(5))
            0:       entry = '0;
            1:       entry = '1;
            default: entry = $urandom_range(0, 24);
        endcase
        apply_config({$urandom, $urandom}, {$urandom, $urandom}, care, len,
                     $urandom_range(2) == 0, entry);
    endtask

    // random file, often carrying a full or partial copy of the signature
    task automatic send_random_file();
        wsm_pkg::byte_t bytes[$];
        int             n;
        int             flen;
        int             at;
        int             plen;
        n = match_len();
        case ($urandom_range(9))
            0:       flen = $urandom_range(1, n);
            1:       flen = $urandom_range(n + 1, n + 40);
            default: flen = $urandom_range(n + 1, n + 10);
        endcase
        at = $urandom_range(0, flen - 1);
        if (ep_r && entry_r < flen && $urandom_range(2) != 0)
            at = entry_r;
        plen = ($urandom_range(3) == 0) ? $urandom_range(0, n) : n;
        if ($urandom_range(5) == 0)
            plen = 0;
        for (int i = 0; i < flen; i++)
        begin
            if (i >= at && i - at < plen)
                bytes.push_back(planted_byte(i - at));
            else
                bytes.push_back(wsm_pkg::byte_t'($urandom));
        end
        send_file(bytes);
    endtask

    task automatic test_reset_defaults();
        send_file('{8'h00});
        send_file('{8'hFF, 8'h00});
    endtask

    task automatic test_exact_and_partial();
        apply_config(64'h3CA5, 64'h0, 32'hF, 5'd2, 1'b0, 32'h0);
        send_file('{8'hA5, 8'h3C, 8'h77});
        send_file('{8'h11, 8'hA5, 8'h00});
        send_file('{8'hA5, 8'h3C});
    endtask

    task automatic test_nibble_wildcards();
        apply_config(64'h3CA5, 64'h0, 32'b1001, 5'd2, 1'b0, 32'h0);
        send_file('{8'hA0, 8'hFC, 8'h00});
        send_file('{8'h50, 8'hFC, 8'h00});
    endtask

    task automatic test_entry_window();
        apply_config(64'h3CA5, 64'h0, 32'hF, 5'd2, 1'b1, 32'h1);
        send_file('{8'h00, 8'hA5, 8'h3C, 8'h00});
        apply_config(64'h3CA5, 64'h0, 32'hF, 5'd2, 1'b1, 32'hFFFF_FFFF);
        send_file('{8'h00, 8'hA5, 8'h3C, 8'h00});
    endtask

    task automatic test_output_backpressure();
        apply_config({$urandom, $urandom}, 64'h0, 32'h3, 5'd1, 1'b0, 32'h0);
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        rx_holds_req++;
        repeat (20)
            send_random_file();
    endtask

    task automatic test_random_files();
        int target;
        int phase;
        target = beats_sent + RANDOM_BEATS;
        phase  = 0;
        while (beats_sent < target)
        begin
            if (phase == 0)
                apply_config('1, '1, '1, 5'd31, 1'b0, 32'h0);
            else if (phase == 1)
                apply_config('0, '0, '0, 5'd0, 1'b1, '1);
            else
                pick_random_config();
            case ($urandom_range(2))
                0:       tx_gap_pct = 0;
                1:       tx_gap_pct = 20;
                default: tx_gap_pct = 60;
            endcase
            case ($urandom_range(2))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 20;
                default: rx_stall_pct = 60;
            endcase
            repeat ($urandom_range(3, 8))
                send_random_file();
            phase++;
        end
    endtask

    initial
    begin
        rx_holds_done = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_holds_done < rx_holds_req)
            begin
                rx_holds_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if ($urandom_range(99) < rx_stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap()) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic flag_result(input string why, input verdict_t want, input verdict_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected best %0d full %0b nofit %0b, %s %0d full %0b nofit %0b",
                     $realtime, why, want.best, want.full, want.nofit,
                     "got best", got.best, got.full, got.nofit);
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        verdict_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.best  = m_axis_tdata[4:0];
            got.full  = m_axis_tdata[5];
            got.nofit = m_axis_tdata[6];
            if (pending_verdicts.size() == 0)
            begin
                flag_result("result beat with none pending", '0, got);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.best !== want.best || got.full !== want.full
                    || got.nofit !== want.nofit)
                    flag_result("result mismatch", want, got);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL wildcard_signature_matcher_unit");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = wsm_pkg::CFG_PATTERN_LOW;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        s_axis_tlast   = 1'b0;
        beats_sent     = 0;
        tx_gap_pct     = 20;
        rx_stall_pct   = 20;
        rx_holds_req   = 0;
        sig_lo         = '0;
        sig_hi         = '0;
        care_r         = '0;
        len_r          = wsm_pkg::len_t'(1);
        ep_r           = 1'b0;
        entry_r        = '0;
        clear_scan();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_exact_and_partial();
        test_nibble_wildcards();
        test_entry_window();
        test_output_backpressure();
        test_random_files();

        wait_idle();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS wildcard_signature_matcher_unit");
        else
            $display("FAIL wildcard_signature_matcher_unit");
        $finish;
    end

endmodule
